@@ sv/arp_cache_table_defines.svh @@
// ----------------------------------------------------------------------------
// arp cache table assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define ACT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ACT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg)
`define ACT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

@@ sv/act_pkg.sv @@
// ----------------------------------------------------------------------------
// arp cache table package
// table sizing, field widths, controller command struct and helpers
// ----------------------------------------------------------------------------
`default_nettype none

package act_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic capture_vec;
        logic capture_idx;
        logic execute;
    } act_cmd_t;

    // lowest set bit of a vector, zero when none is set
    function automatic logic [IDX_W-1:0] lowest_set(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // low bits of a slot number as reported on the result
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/act_ctrl.sv @@
// ----------------------------------------------------------------------------
// arp cache table controller
// sequences compare, encode and execute steps and owns the handshakes
// ----------------------------------------------------------------------------
`default_nettype none
`include "arp_cache_table_defines.svh"

module act_ctrl
    import act_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output act_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_ENC  = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       exec_go;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    // the result register must be free before it is loaded
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;

    always_comb
    begin
        cmd.load_in     = accept;
        cmd.capture_vec = (state_reg == ST_CMP);
        cmd.capture_idx = (state_reg == ST_ENC);
        cmd.execute     = exec_go;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_ENC;
            ST_ENC:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ACT_ASSERT_NEXT(a_accept_starts_cmp, clk, rst_n, accept, state_reg == ST_CMP,
        "accepted transaction did not start a compare")
    `ACT_ASSERT_IMPLY(a_exec_slot_free, clk, rst_n, cmd.execute, !out_valid_reg || m_ready,
        "result register overwritten before it was taken")
    `ACT_ASSERT_IMPLY(a_valid_from_exec, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_EXEC, "result raised outside execute")

endmodule

`default_nettype wire

@@ sv/act_datapath.sv @@
// ----------------------------------------------------------------------------
// arp cache table datapath
// entry storage, parallel address compare, slot selection and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "arp_cache_table_defines.svh"

module act_datapath
    import act_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire act_cmd_t          cmd,
    input  wire logic              in_action,
    input  wire logic [IP_W-1:0]   in_ip,
    input  wire logic [MAC_W-1:0]  in_mac,
    output logic                   out_hit,
    output logic [MAC_W-1:0]       out_mac,
    output logic [SLOT_W-1:0]      out_slot
);

    logic                 entry_valid_reg [ENTRIES];
    logic [IP_W-1:0]      entry_ip_reg    [ENTRIES];
    logic [MAC_W-1:0]     entry_mac_reg   [ENTRIES];

    logic                 act_reg;
    logic [IP_W-1:0]      ip_reg;
    logic [MAC_W-1:0]     mac_reg;
    logic [ENTRIES-1:0]   match_vec_next;
    logic [ENTRIES-1:0]   free_vec_next;
    logic [ENTRIES-1:0]   match_vec_reg;
    logic [ENTRIES-1:0]   free_vec_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     tgt_idx_reg;
    logic                 out_hit_reg;
    logic [MAC_W-1:0]     out_mac_reg;
    logic [SLOT_W-1:0]    out_slot_reg;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec_next[i] = entry_valid_reg[i] && (entry_ip_reg[i] == ip_reg);
            free_vec_next[i]  = !entry_valid_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= in_action;
            ip_reg  <= in_ip;
            mac_reg <= in_mac;
        end
        if (cmd.capture_vec)
        begin
            free_vec_reg <= free_vec_next;
        end
        if (cmd.capture_idx)
        begin
            hit_reg     <= |match_vec_reg;
            // existing entry first, then lowest free slot, slot 0 when full
            tgt_idx_reg <= (|match_vec_reg) ? lowest_set(match_vec_reg)
                                            : lowest_set(free_vec_reg);
        end
        if (cmd.execute)
        begin
            out_hit_reg  <= hit_reg;
            out_mac_reg  <= (!act_reg && hit_reg) ? entry_mac_reg[tgt_idx_reg] : '0;
            out_slot_reg <= (!act_reg && !hit_reg) ? '0 : slot_of(tgt_idx_reg);
            if (act_reg)
            begin
                entry_mac_reg[tgt_idx_reg] <= mac_reg;
                if (!hit_reg)
                begin
                    entry_ip_reg[tgt_idx_reg] <= ip_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_vec_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.capture_vec)
            begin
                match_vec_reg <= match_vec_next;
            end
            if (cmd.execute && act_reg && !hit_reg)
            begin
                entry_valid_reg[tgt_idx_reg] <= 1'b1;
            end
        end
    end

    assign out_hit  = out_hit_reg;
    assign out_mac  = out_mac_reg;
    assign out_slot = out_slot_reg;

    `ACT_ASSERT_IMPLY(a_single_match, clk, rst_n, cmd.capture_idx, $onehot0(match_vec_reg),
        "address held by more than one valid entry")
    `ACT_ASSERT_NEXT(a_learn_sets_valid, clk, rst_n, cmd.execute && act_reg,
        entry_valid_reg[$past(tgt_idx_reg)], "learnt entry not valid")
    `ACT_ASSERT_NEXT(a_miss_zero, clk, rst_n, cmd.execute && !act_reg && !hit_reg,
        out_mac_reg == '0 && out_slot_reg == '0, "lookup miss gave non-zero result")

endmodule

`default_nettype wire

@@ sv/arp_cache_table.sv @@
// ----------------------------------------------------------------------------
// arp cache table
// fully associative ipv4 to mac table with lookup and learn transactions
// an accepted input steps through the compare, encode and execute states, and the
// result is registered once execute finds the result register free; a new input
// is taken only in idle, but may be taken while the previous result still waits
// reset clears all valid bits at once, entry contents are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table
    import act_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
    input  wire logic        s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // mac_out[47:0], slot[51:48], zero pad
    output logic             m_axis_tuser   // hit
);

    act_cmd_t             cmd;
    logic [MAC_W-1:0]     out_mac;
    logic [SLOT_W-1:0]    out_slot;

    act_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    act_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_action (s_axis_tuser),
        .in_ip     (s_axis_tdata[31:0]),
        .in_mac    (s_axis_tdata[79:32]),
        .out_hit   (m_axis_tuser),
        .out_mac   (out_mac),
        .out_slot  (out_slot)
    );

    assign m_axis_tdata = {4'b0000, out_slot, out_mac};

endmodule

`default_nettype wire

@@ tb/sv/arp_cache_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// arp cache table testbench package
// transaction codes shared by the stimulus and the checker
// ----------------------------------------------------------------------------
package arp_cache_tb_pkg;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_LEARN  = 1'b1
    } arp_action_t;

endpackage

@@ tb/sv/arp_cache_checker.sv @@
// ----------------------------------------------------------------------------
// arp cache table checker
// watches both stream channels, keeps a shadow copy of the table, predicts
// the answer to every accepted transaction and compares each result in order
// ----------------------------------------------------------------------------
module arp_cache_checker
    import act_pkg::*;
    import arp_cache_tb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
    input  wire logic        s_axis_tuser,  // action
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [55:0] m_axis_tdata,  // mac_out[47:0], slot[51:48], zero pad
    input  wire logic        m_axis_tuser,  // hit
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output int               hit_count,
    output int               evict_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
        logic [SLOT_W-1:0] slot;
    } arp_answer_t;

    logic              shadow_valid [ENTRIES];
    logic [IP_W-1:0]   shadow_ip    [ENTRIES];
    logic [MAC_W-1:0]  shadow_mac   [ENTRIES];
    arp_answer_t       answers_due  [$];

    // updates the shadow table and returns the answer the block owes
    function automatic arp_answer_t resolve_arp(input arp_action_t action,
                                                input logic [IP_W-1:0] ip,
                                                input logic [MAC_W-1:0] mac);
        arp_answer_t ans;
        int          found;
        int          target;
        ans   = '0;
        found = -1;
        // lowest matching slot wins
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (shadow_valid[i] && shadow_ip[i] == ip)
            begin
                found = i;
            end
        end
        if (action == OP_LOOKUP)
        begin
            if (found >= 0)
            begin
                ans.hit  = 1'b1;
                ans.mac  = shadow_mac[found];
                ans.slot = SLOT_W'(found);
            end
            return ans;
        end
        if (found >= 0)
        begin
            shadow_mac[found] = mac;
            target = found;
        end
        else
        begin
            // lowest free slot, or slot 0 once the table is full
            target = 0;
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (!shadow_valid[i])
                begin
                    target = i;
                end
            end
            if (shadow_valid[target])
            begin
                evict_count++;
            end
            shadow_ip[target]    = ip;
            shadow_mac[target]   = mac;
            shadow_valid[target] = 1'b1;
        end
        ans.hit  = (found >= 0);
        ans.slot = SLOT_W'(target);
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arp_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                shadow_valid[i] = 1'b0;
            end
            answers_due.delete();
            fail_count   = 0;
            pending      = 0;
            result_count = 0;
            hit_count    = 0;
            evict_count  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (answers_due.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: hit %0b mac %h slot %0d",
                           m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[51:48]);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.hit)
                    begin
                        hit_count++;
                    end
                    if (m_axis_tuser !== want.hit)
                    begin
                        $error("hit mismatch: expected %0b, got %0b", want.hit, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[47:0] !== want.mac)
                    begin
                        $error("mac_out mismatch: expected %h, got %h",
                               want.mac, m_axis_tdata[47:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[51:48] !== want.slot)
                    begin
                        $error("slot mismatch: expected %0d, got %0d",
                               want.slot, m_axis_tdata[51:48]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                answers_due.push_back(resolve_arp(arp_action_t'(s_axis_tuser),
                                                  s_axis_tdata[31:0], s_axis_tdata[79:32]));
            end
            pending = answers_due.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// arp cache table testbench
// directed fill, update and full-table overwrite sequences followed by random
// lookups and learns over a small address pool, with random idling on both
// channels and one long result stall; checking is done by arp_cache_checker
// ----------------------------------------------------------------------------
module testbench;
    import arp_cache_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 750;
    localparam int POOL_SIZE    = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    int          fail_count;
    int          pending;
    int          result_count;
    int          hit_count;
    int          evict_count;
    bit          steady;
    logic [31:0] known_ips [POOL_SIZE];

    arp_cache_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    arp_cache_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .hit_count     (hit_count),
        .evict_count   (evict_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        int  hold_left;
        int  taken;
        bit  held;
        hold_left = 0;
        taken     = 0;
        held      = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                taken++;
            end
            if (!held && taken == 100)
            begin
                held      = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= steady || ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_item(input arp_action_t action, input logic [31:0] ip,
                             input logic [47:0] mac);
        while (!steady && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mac, ip};
        s_axis_tuser  <= action;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    initial
    begin
        logic [31:0] ip;
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOOKUP;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            known_ips[k] = $urandom;
        end
        @(posedge rst_n);
        @(posedge clk);

        // empty table, extreme addresses, then update of an existing entry
        send_item(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        send_item(OP_LEARN,  32'h0000_0000, 48'h0);
        send_item(OP_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        send_item(OP_LEARN,  32'h0000_0000, 48'hAAAA_5555_AAAA);
        send_item(OP_LOOKUP, 32'h0000_0000, 48'h0);
        // fill the remaining slots
        for (int i = 2; i < 16; i++)
        begin
            send_item(OP_LEARN, 32'h0A00_0000 + i, {16'h0200, 32'(i)});
        end
        // table full: slot 0 is overwritten and its old address is gone
        send_item(OP_LEARN,  32'hC0A8_0101, 48'h5555_AAAA_5555);
        send_item(OP_LOOKUP, 32'h0000_0000, 48'h0);
        send_item(OP_LOOKUP, 32'hC0A8_0101, 48'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 300 && n < 450);
            if ($urandom_range(99) < 85)
            begin
                ip = known_ips[$urandom_range(POOL_SIZE - 1)];
            end
            else
            begin
                ip = $urandom;
            end
            send_item(arp_action_t'($urandom_range(1)), ip, 48'({$urandom, $urandom}));
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        // let the checker register the last accepted transaction first
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d lookup and learn results checked, %0d of them hits", result_count,
                 hit_count);
        $display("%0d learns on a full table overwrote slot 0", evict_count);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/act_pkg.sv
sv/act_ctrl.sv
sv/act_datapath.sv
sv/arp_cache_table.sv
tb/sv/arp_cache_tb_pkg.sv
tb/sv/arp_cache_checker.sv
tb/sv/testbench.sv
